>>> hdl/wtsc_pkg.sv
// shared types, constants and helper functions for the wave-table sound channel
package wtsc_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_FREQ  = 2'd2,
    MODE_LEN   = 2'd3
  } mode_t;

  localparam int          NUM_CTRL   = 5;
  localparam int          WAVE_DEPTH = 16;
  localparam int          WAVE_AW    = $clog2(WAVE_DEPTH);
  localparam int          PERIOD_W   = 13;
  localparam int          LEN_W      = 9;
  localparam int          POS_W      = 5;
  localparam int          VOL_W      = 3;
  localparam int          IN_DATA_W  = 24;
  localparam int          OUT_DATA_W = 16;

  localparam logic [15:0] NR30_ADDR  = 16'hFF1A;
  localparam logic [15:0] NR34_ADDR  = 16'hFF1E;
  localparam logic [11:0] WAVE_PAGE  = 12'hFF3;

  localparam logic [2:0]  REG_NR30   = 3'd0;
  localparam logic [2:0]  REG_NR31   = 3'd1;
  localparam logic [2:0]  REG_NR32   = 3'd2;
  localparam logic [2:0]  REG_NR33   = 3'd3;
  localparam logic [2:0]  REG_NR34   = 3'd4;

  localparam logic [7:0]  MASK_NR30  = 8'h7F;
  localparam logic [7:0]  MASK_NR31  = 8'hFF;
  localparam logic [7:0]  MASK_NR32  = 8'h9F;
  localparam logic [7:0]  MASK_NR33  = 8'hFF;
  localparam logic [7:0]  MASK_NR34  = 8'hBF;
  localparam logic [7:0]  OPEN_BUS   = 8'hFF;

  localparam logic [11:0]      FREQ_BASE = 12'h800;
  localparam logic [LEN_W-1:0] LEN_FULL  = 9'd256;
  localparam logic [VOL_W-1:0] VOL_MUTE  = 3'd4;

  typedef struct packed {
    logic               we;
    logic [WAVE_AW-1:0] addr;
    logic [7:0]         data;
  } wave_wr_t;

  typedef struct packed {
    logic             rd_ram;
    logic [7:0]       rd_byte;
    logic             nib_lo;
    logic [VOL_W-1:0] vol;
    logic             running;
  } side_t;

  function automatic logic [PERIOD_W-1:0] period_reload(input logic [7:0] lo,
                                                        input logic [2:0] hi);
    logic [11:0] span;
    span = FREQ_BASE - {1'b0, hi, lo};
    return {span, 1'b0};
  endfunction

  function automatic logic [VOL_W-1:0] vol_code(input logic [1:0] sel);
    logic [VOL_W-1:0] v;
    case (sel)
      2'd0:    v = VOL_MUTE;
      2'd1:    v = 3'd0;
      2'd2:    v = 3'd1;
      default: v = 3'd2;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/wtsc_ctrl.sv
// control bytes, timers, position and bus decode for one item per cycle while en is high
module wtsc_ctrl
  import wtsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  mode_t              mode,
  input  logic [15:0]        addr,
  input  logic [7:0]         wdata,
  output wave_wr_t           wave_wr,
  output logic [WAVE_AW-1:0] rd_addr,
  output logic [WAVE_AW-1:0] nib_addr,
  output side_t              side
);

  logic [7:0]          ctrl_r   [NUM_CTRL];
  logic [7:0]          ctrl_nxt [NUM_CTRL];
  logic                chan_r, chan_nxt;
  logic                dac_r, dac_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [PERIOD_W-1:0] per_r, per_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [VOL_W-1:0]    vol_r, vol_nxt;
  logic [15:0]         offs;
  logic [2:0]          reg_idx;
  logic                in_ctrl;
  logic                in_wave;

  always_comb begin
    offs    = addr - NR30_ADDR;
    reg_idx = offs[2:0];
    in_ctrl = (addr >= NR30_ADDR) && (addr <= NR34_ADDR);
    in_wave = (addr[15:4] == WAVE_PAGE);

    for (int i = 0; i < NUM_CTRL; i++) begin
      ctrl_nxt[i] = ctrl_r[i];
    end
    chan_nxt = chan_r;
    dac_nxt  = dac_r;
    len_nxt  = len_r;
    per_nxt  = per_r;
    pos_nxt  = pos_r;
    vol_nxt  = vol_r;

    wave_wr.we   = 1'b0;
    wave_wr.addr = addr[WAVE_AW-1:0];
    wave_wr.data = wdata;
    side.rd_ram  = 1'b0;
    side.rd_byte = 8'h00;

    unique case (mode)
      MODE_WRITE: begin
        if (in_ctrl) begin
          for (int i = 0; i < NUM_CTRL; i++) begin
            if (reg_idx == 3'(i)) begin
              ctrl_nxt[i] = wdata;
            end
          end
          unique case (reg_idx)
            REG_NR30: dac_nxt = wdata[7];
            REG_NR31: len_nxt = LEN_FULL - {1'b0, wdata};
            REG_NR34: begin
              // trigger
              if (wdata[7]) begin
                chan_nxt = 1'b1;
                if (len_r == '0) begin
                  len_nxt = LEN_FULL;
                end
                per_nxt = period_reload(ctrl_r[REG_NR33], wdata[2:0]);
                pos_nxt = '0;
              end
            end
            default: ;
          endcase
        end else if (in_wave) begin
          wave_wr.we = 1'b1;
        end
      end
      MODE_READ: begin
        if (in_ctrl) begin
          unique case (reg_idx)
            REG_NR30: side.rd_byte = ctrl_r[REG_NR30] | MASK_NR30;
            REG_NR31: side.rd_byte = ctrl_r[REG_NR31] | MASK_NR31;
            REG_NR32: side.rd_byte = ctrl_r[REG_NR32] | MASK_NR32;
            REG_NR33: side.rd_byte = ctrl_r[REG_NR33] | MASK_NR33;
            REG_NR34: side.rd_byte = ctrl_r[REG_NR34] | MASK_NR34;
            default:  side.rd_byte = OPEN_BUS;
          endcase
        end else if (in_wave) begin
          side.rd_ram = 1'b1;
        end else begin
          side.rd_byte = OPEN_BUS;
        end
      end
      MODE_FREQ: begin
        vol_nxt = (chan_r && dac_r) ? vol_code(ctrl_r[REG_NR32][6:5]) : VOL_MUTE;
        if (per_r <= PERIOD_W'(1)) begin
          per_nxt = period_reload(ctrl_r[REG_NR33], ctrl_r[REG_NR34][2:0]);
          pos_nxt = pos_r + POS_W'(1);
        end else begin
          per_nxt = per_r - PERIOD_W'(1);
        end
      end
      MODE_LEN: begin
        if (ctrl_r[REG_NR34][6] && (len_r != '0)) begin
          len_nxt = len_r - LEN_W'(1);
          if (len_r == LEN_W'(1)) begin
            chan_nxt = 1'b0;
          end
        end
      end
    endcase

    rd_addr      = addr[WAVE_AW-1:0];
    nib_addr     = pos_nxt[POS_W-1:1];
    side.nib_lo  = pos_nxt[0];
    side.vol     = vol_nxt;
    side.running = chan_nxt && dac_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CTRL; i++) begin
        ctrl_r[i] <= 8'h00;
      end
      chan_r <= 1'b0;
      dac_r  <= 1'b0;
      len_r  <= '0;
      per_r  <= '0;
      pos_r  <= '0;
      vol_r  <= '0;
    end else if (en) begin
      for (int i = 0; i < NUM_CTRL; i++) begin
        ctrl_r[i] <= ctrl_nxt[i];
      end
      chan_r <= chan_nxt;
      dac_r  <= dac_nxt;
      len_r  <= len_nxt;
      per_r  <= per_nxt;
      pos_r  <= pos_nxt;
      vol_r  <= vol_nxt;
    end
  end

endmodule

>>> hdl/wtsc_wave_ram.sv
// 16-byte wave ram, one write port and two registered read ports
module wtsc_wave_ram
  import wtsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  wave_wr_t           wave_wr,
  input  logic [WAVE_AW-1:0] rd_addr,
  input  logic [WAVE_AW-1:0] nib_addr,
  output logic [7:0]         rd_data,
  output logic [7:0]         nib_data
);

  logic [7:0]            mem [WAVE_DEPTH];
  logic [WAVE_DEPTH-1:0] vld_r;
  logic [7:0]            rd_data_r;
  logic [7:0]            nib_data_r;
  logic                  wr_en;

  assign wr_en = en && wave_wr.we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wave_wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wave_wr.addr] <= wave_wr.data;
    end
  end

  // write-first on both read ports, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (en) begin
      if (wr_en && (wave_wr.addr == rd_addr)) begin
        rd_data_r <= wave_wr.data;
      end else begin
        rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : 8'h00;
      end
      if (wr_en && (wave_wr.addr == nib_addr)) begin
        nib_data_r <= wave_wr.data;
      end else begin
        nib_data_r <= vld_r[nib_addr] ? mem[nib_addr] : 8'h00;
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign nib_data = nib_data_r;

endmodule

>>> hdl/wtsc_out.sv
// sideband stage and result register: read data select, nibble pick and volume shift
module wtsc_out
  import wtsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  load_side,
  input  logic                  load_out,
  input  side_t                 side,
  input  logic [7:0]            rd_data,
  input  logic [7:0]            nib_data,
  output logic [OUT_DATA_W-1:0] out_data
);

  side_t                 side_r;
  logic [7:0]            rd_byte;
  logic [3:0]            nib;
  logic [3:0]            amp;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  always_ff @(posedge clk) begin
    if (load_side) begin
      side_r <= side;
    end
  end

  always_comb begin
    rd_byte      = side_r.rd_ram ? rd_data : side_r.rd_byte;
    nib          = side_r.nib_lo ? nib_data[3:0] : nib_data[7:4];
    amp          = nib >> side_r.vol;
    out_data_nxt = {3'b000, side_r.running, amp, rd_byte};
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

>>> hdl/wave_table_sound_channel.sv
// top level of the wave-table sound channel
//
//  channel | ports                          | contents
//  --------+--------------------------------+------------------------------------------
//  in      | in_tvalid in_tready            | tuser: mode; tdata: address, write_data
//  out     | out_tvalid out_tready          | tdata: read_data, amplitude, running
//
//  one transaction per cycle sustained while out_tready holds; an accepted transaction passes
//  the input register, the state update with wave ram read, then the result register
//  rst_n is synchronous; the wave ram uses per-byte valid bits, so no clearing pass
//  a stalled result holds its stage while the earlier stages keep filling
module wave_table_sound_channel
  import wtsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // address[15:0], write_data[23:16]
  input  logic [1:0]            in_tuser,   // mode[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // read_data[7:0], amplitude[11:8], running[12]
);

  logic               v1_r, v1_nxt;
  logic               v2_r, v2_nxt;
  logic               v3_r, v3_nxt;
  mode_t              mode_r;
  logic [15:0]        addr_r;
  logic [7:0]         wdata_r;
  logic               in_acc;
  logic               adv1;
  logic               adv2;
  logic               s2_ready;
  wave_wr_t           wave_wr;
  logic [WAVE_AW-1:0] rd_addr;
  logic [WAVE_AW-1:0] nib_addr;
  logic [7:0]         rd_data;
  logic [7:0]         nib_data;
  side_t              side;

  always_comb begin
    adv2      = v2_r && (!v3_r || out_tready);
    s2_ready  = !v2_r || adv2;
    adv1      = v1_r && s2_ready;
    in_tready = !v1_r || s2_ready;
    in_acc    = in_tvalid && in_tready;
    v1_nxt    = in_acc ? 1'b1 : (adv1 ? 1'b0 : v1_r);
    v2_nxt    = adv1 ? 1'b1 : (adv2 ? 1'b0 : v2_r);
    v3_nxt    = adv2 ? 1'b1 : ((out_tvalid && out_tready) ? 1'b0 : v3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= mode_t'(in_tuser);
      addr_r  <= in_tdata[15:0];
      wdata_r <= in_tdata[23:16];
    end
  end

  wtsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv1),
    .mode     (mode_r),
    .addr     (addr_r),
    .wdata    (wdata_r),
    .wave_wr  (wave_wr),
    .rd_addr  (rd_addr),
    .nib_addr (nib_addr),
    .side     (side)
  );

  wtsc_wave_ram u_wave_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv1),
    .wave_wr  (wave_wr),
    .rd_addr  (rd_addr),
    .nib_addr (nib_addr),
    .rd_data  (rd_data),
    .nib_data (nib_data)
  );

  wtsc_out u_out (
    .clk       (clk),
    .load_side (adv1),
    .load_out  (adv2),
    .side      (side),
    .rd_data   (rd_data),
    .nib_data  (nib_data),
    .out_data  (out_tdata)
  );

  assign out_tvalid = v3_r;

`ifndef SYNTHESIS
  a_wave_wr_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (adv1 && wave_wr.we) |-> (mode_r == MODE_WRITE))
    else $error("wave ram written by a non-write transaction");

  a_ram_read_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (adv1 && side.rd_ram) |-> (mode_r == MODE_READ))
    else $error("wave ram read data selected for a non-read transaction");

  a_result_from_stage2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v3_r) |-> $past(v2_r))
    else $error("result appeared without a transaction in the middle stage");

  a_stage2_from_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v2_r) |-> $past(v1_r))
    else $error("middle stage filled without an input transaction");
`endif

endmodule

>>> tb/testbench.sv
// testbench for the wave-table sound channel: stream stimulus, shadow state and result checks
`timescale 1ns / 1ps

module testbench
  import wtsc_pkg::*;
();

  typedef struct packed {
    logic       running;
    logic [3:0] amplitude;
    logic [7:0] read_data;
  } chan_result_t;

  class wave_channel_shadow;
    logic [7:0]          ctrl [NUM_CTRL];
    logic [7:0]          wave [WAVE_DEPTH];
    logic                enabled;
    logic                dac;
    logic [LEN_W-1:0]    len_left;
    logic [PERIOD_W-1:0] period_left;
    logic [POS_W-1:0]    pos;
    logic [VOL_W-1:0]    shift;
    chan_result_t        pending_results [$];
    int                  mismatches;

    function new();
      foreach (ctrl[i]) ctrl[i] = '0;
      foreach (wave[i]) wave[i] = '0;
      enabled     = 1'b0;
      dac         = 1'b0;
      len_left    = '0;
      period_left = '0;
      pos         = '0;
      shift       = '0;
      mismatches  = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function logic [PERIOD_W-1:0] reload_value();
      int freq;
      freq = int'({ctrl[REG_NR34][2:0], ctrl[REG_NR33]});
      return PERIOD_W'((int'(FREQ_BASE) - freq) * 2);
    endfunction

    function logic [7:0] fixed_bits(logic [2:0] idx);
      case (idx)
        REG_NR30: return MASK_NR30;
        REG_NR31: return MASK_NR31;
        REG_NR32: return MASK_NR32;
        REG_NR33: return MASK_NR33;
        default:  return MASK_NR34;
      endcase
    endfunction

    // apply one accepted transaction and queue the result it produces
    function void note_input(mode_t m, logic [15:0] a, logic [7:0] d);
      chan_result_t r;
      logic [2:0]   idx;
      logic         in_ctrl;
      logic         in_wave;
      logic [7:0]   b;
      logic [3:0]   nib;
      r       = '0;
      idx     = 3'(a - NR30_ADDR);
      in_ctrl = (a >= NR30_ADDR) && (a <= NR34_ADDR);
      in_wave = (a[15:4] == WAVE_PAGE);
      case (m)
        MODE_WRITE: begin
          if (in_ctrl) begin
            ctrl[idx] = d;
            if (idx == REG_NR30) begin
              dac = d[7];
            end else if (idx == REG_NR31) begin
              len_left = LEN_FULL - LEN_W'(d);
            end else if (idx == REG_NR34 && d[7]) begin
              enabled = 1'b1;
              if (len_left == '0) len_left = LEN_FULL;
              period_left = reload_value();
              pos         = '0;
            end
          end else if (in_wave) begin
            wave[a[3:0]] = d;
          end
        end
        MODE_READ: begin
          if (in_ctrl) r.read_data = ctrl[idx] | fixed_bits(idx);
          else if (in_wave) r.read_data = wave[a[3:0]];
          else r.read_data = OPEN_BUS;
        end
        MODE_FREQ: begin
          if (enabled && dac) begin
            if (ctrl[REG_NR32][6:5] == 2'd0) shift = VOL_MUTE;
            else shift = VOL_W'(ctrl[REG_NR32][6:5] - 2'd1);
          end else begin
            shift = VOL_MUTE;
          end
          if (period_left <= 1) begin
            period_left = reload_value();
            pos         = pos + 1'b1;
          end else begin
            period_left = period_left - 1'b1;
          end
        end
        default: begin
          if (ctrl[REG_NR34][6] && len_left != '0) begin
            len_left = len_left - 1'b1;
            if (len_left == '0) enabled = 1'b0;
          end
        end
      endcase
      b           = wave[pos[4:1]];
      nib         = pos[0] ? b[3:0] : b[7:4];
      r.amplitude = nib >> shift;
      r.running   = enabled && dac;
      pending_results.push_back(r);
    endfunction

    function void flag_mismatch(string what, chan_result_t want, chan_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch (%s): exp rd=%02h amp=%h run=%b  got rd=%02h amp=%h run=%b",
                 what, want.read_data, want.amplitude, want.running,
                 got.read_data, got.amplitude, got.running);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] td);
      chan_result_t got;
      chan_result_t want;
      got = td[12:0];
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected transaction", '0, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data !== want.read_data || got.amplitude !== want.amplitude ||
          got.running !== want.running)
        flag_mismatch("field", want, got);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  wave_channel_shadow shadow = new();

  int send_gap_pct = 33;
  int recv_gap_pct = 55;
  int items_sent   = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit hold_request = 1'b0;

  localparam int QUIET_LIMIT = 2000;

  wave_table_sound_channel u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial out_tready = 1'b0;

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = 60;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
          $display("** wave_table_sound_channel: FAILED **");
          $finish;
        end
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_item(input mode_t m, input logic [15:0] a, input logic [7:0] d);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d, a};
    in_tuser  <= m;
    do @(posedge clk); while (!in_tready);
    shadow.note_input(m, a, d);
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding result, returns at a rising edge
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  task automatic run_random(input int target);
    int          p;
    int          ticks;
    logic [15:0] a;
    logic [7:0]  d;
    mode_t       m;
    while (items_sent < target) begin
      if ($urandom_range(99) < 25) begin
        // full note setup with trigger, then a burst of ticks
        send_item(MODE_WRITE, NR30_ADDR, {1'($urandom_range(3) != 0), 7'($urandom)});
        send_item(MODE_WRITE, NR30_ADDR + 16'(REG_NR31),
                  $urandom_range(1) ? 8'($urandom_range(240, 255)) : 8'($urandom));
        send_item(MODE_WRITE, NR30_ADDR + 16'(REG_NR32), 8'($urandom));
        send_item(MODE_WRITE, NR30_ADDR + 16'(REG_NR33), 8'($urandom_range(224, 255)));
        send_item(MODE_WRITE, NR34_ADDR,
                  {1'b1, 1'($urandom), 3'($urandom), 3'($urandom_range(6, 7))});
        ticks = $urandom_range(6, 24);
        repeat (ticks)
          send_item(($urandom_range(3) != 0) ? MODE_FREQ : MODE_LEN,
                    16'($urandom), 8'($urandom));
      end else begin
        p = $urandom_range(99);
        if (p < 22) m = MODE_WRITE;
        else if (p < 40) m = MODE_READ;
        else if (p < 85) m = MODE_FREQ;
        else m = MODE_LEN;
        p = $urandom_range(99);
        if (p < 40) begin
          a = {WAVE_PAGE, 4'($urandom)};
        end else if (p < 80) begin
          a = NR30_ADDR + 16'($urandom_range(NUM_CTRL - 1));
        end else if (p < 90) begin
          case ($urandom_range(3))
            0:       a = NR30_ADDR - 16'd1;
            1:       a = NR34_ADDR + 16'd1;
            2:       a = {WAVE_PAGE, 4'h0} - 16'd1;
            default: a = {WAVE_PAGE, 4'hF} + 16'd1;
          endcase
        end else begin
          a = 16'($urandom);
        end
        d = 8'($urandom);
        send_item(m, a, d);
      end
    end
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_WRITE;
    rst_n     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values, open bus and a tick with a zero period
    send_item(MODE_READ, NR30_ADDR, 8'h00);
    send_item(MODE_FREQ, 16'h0000, 8'h00);
    send_item(MODE_READ, 16'h0000, 8'hFF);
    send_item(MODE_READ, 16'hFFFF, 8'h00);
    // wave ram edges and writes just outside both windows
    send_item(MODE_WRITE, {WAVE_PAGE, 4'h0}, 8'hA5);
    send_item(MODE_WRITE, {WAVE_PAGE, 4'hF}, 8'h5A);
    send_item(MODE_WRITE, NR34_ADDR + 16'd1, 8'hFF);
    send_item(MODE_WRITE, {WAVE_PAGE, 4'h0} - 16'd1, 8'hFF);
    send_item(MODE_READ, {WAVE_PAGE, 4'h0}, 8'h00);
    send_item(MODE_READ, {WAVE_PAGE, 4'hF}, 8'h00);
    send_item(MODE_READ, {WAVE_PAGE, 4'hF} + 16'd1, 8'h00);
    // dac on, length of one, full volume, highest frequency, trigger with length enable
    send_item(MODE_WRITE, NR30_ADDR, 8'h80);
    send_item(MODE_WRITE, NR30_ADDR + 16'(REG_NR31), 8'hFF);
    send_item(MODE_WRITE, NR30_ADDR + 16'(REG_NR32), 8'h20);
    send_item(MODE_WRITE, NR30_ADDR + 16'(REG_NR33), 8'hFF);
    send_item(MODE_WRITE, NR34_ADDR, 8'hC7);
    repeat (3) send_item(MODE_FREQ, 16'hFFFF, 8'hFF);
    send_item(MODE_READ, NR30_ADDR + 16'(REG_NR32), 8'h00);
    send_item(MODE_READ, NR34_ADDR, 8'h00);
    // length runs out, then a tick with zero length left
    send_item(MODE_LEN, 16'h0000, 8'h00);
    send_item(MODE_LEN, 16'hFFFF, 8'hFF);
    send_item(MODE_FREQ, 16'h0000, 8'h00);
    // trigger with zero length and lowest frequency, other volume code, dac off
    send_item(MODE_WRITE, NR30_ADDR + 16'(REG_NR33), 8'h00);
    send_item(MODE_WRITE, NR34_ADDR, 8'h80);
    send_item(MODE_WRITE, NR30_ADDR + 16'(REG_NR32), 8'h60);
    send_item(MODE_FREQ, 16'h0000, 8'h00);
    send_item(MODE_WRITE, NR30_ADDR, 8'h00);
    send_item(MODE_READ, NR30_ADDR + 16'(REG_NR31), 8'h00);

    run_random(560);
    settle();
    send_gap_pct = 55;
    recv_gap_pct = 33;
    @(negedge clk);
    run_random(1110);
    settle();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_request = 1'b1;
    @(negedge clk);
    run_random(1660);
    settle();
    repeat (8) @(posedge clk);

    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("** wave_table_sound_channel: PASSED **");
    end else begin
      $display("** wave_table_sound_channel: FAILED **");
    end
    $finish;
  end

endmodule
